### rtl/core/arx_pkg.sv
package arx_pkg;

  // Sizes of the stores and the datapath.
  localparam int MAX_ORDER  = 8;
  localparam int MAX_DELAY  = 8;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int IN_DEPTH   = MAX_ORDER + MAX_DELAY;
  localparam int ORD_IDX_W  = $clog2(MAX_ORDER);
  localparam int HIST_IDX_W = $clog2(IN_DEPTH);
  localparam int CNT_W      = $clog2(2 * MAX_ORDER);
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + 8;
  localparam int FRAC_SHIFT = 14;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TAPS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_ORDER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_ENABLE = 3'd6;

  // Transaction modes.
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_SIM   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic issue;  // multiply the operands this cycle
    logic neg;    // subtract the product instead of adding it
  } mac_ctrl_t;

endpackage

### rtl/core/arx_mac.sv
module arx_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  arx_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [arx_pkg::COEF_W-1:0]     op_coef,
  input  logic signed [arx_pkg::SAMPLE_W-1:0]   op_sample,
  output logic signed [arx_pkg::ACC_W-1:0]      acc
);
  import arx_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic                     neg_r;
  logic                     pv_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;

  // The product is registered; it joins the sum in the next cycle.
  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod_r <= op_coef * op_sample;
      neg_r  <= ctrl.neg;
    end
  end

  assign prod_ext = ACC_W'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (pv_r) begin
      acc_nxt = neg_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      pv_r  <= ctrl.issue;
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

### rtl/core/arx_plant_step.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  mode, coef_index, coef_a, coef_b,
//                                           sample_in, noise_in
// out_      output     out_valid/out_stall  sample_out
// cfg_      input      cfg_we (no wait)     cfg_index, cfg_data
//
// A load or clear transaction completes in the cycle it is accepted. A
// simulation transaction keeps in_stall high after acceptance while the shared
// multiplier forms one B*u and one A*y product per coefficient pair of the
// effective model order, the product register drains, the result is rounded
// and clamped, and the result is handed over.
// Reset (rst_n low, synchronous) clears histories, coefficients and control state.
// A stall on the output holds the result; the block still takes load and clear
// transactions meanwhile, and a new result waits until the output is free.
module arx_plant_step (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_mode,
  input  logic [2:0]                             in_coef_index,
  input  logic signed [15:0]                     in_coef_a,
  input  logic signed [15:0]                     in_coef_b,
  input  logic signed [15:0]                     in_sample_in,
  input  logic signed [15:0]                     in_noise_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [15:0]                     out_sample_out,
  input  logic                                   cfg_we,
  input  logic [arx_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [arx_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import arx_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam int YFULL_W = ACC_W - FRAC_SHIFT + 1;

  // Configuration registers.
  logic [3:0]                 delay_taps_r;
  logic [3:0]                 model_order_r;
  logic signed [SAMPLE_W-1:0] input_low_r;
  logic signed [SAMPLE_W-1:0] input_high_r;
  logic signed [SAMPLE_W-1:0] output_low_r;
  logic signed [SAMPLE_W-1:0] output_high_r;
  logic [1:0]                 clamp_enable_r;

  // Histories (index 0 is newest) and coefficient stores.
  logic signed [SAMPLE_W-1:0] uhist_r [IN_DEPTH];
  logic signed [SAMPLE_W-1:0] yhist_r [MAX_ORDER];
  logic signed [COEF_W-1:0]   coef_a_r [MAX_ORDER];
  logic signed [COEF_W-1:0]   coef_b_r [MAX_ORDER];

  // Sequencer.
  logic [2:0]                 state_r;
  logic [2:0]                 state_nxt;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           cnt_nxt;
  logic signed [SAMPLE_W-1:0] noise_r;
  logic signed [SAMPLE_W-1:0] y_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r;

  logic                       in_acc;
  logic                       emit_fire;
  logic [3:0]                 n_eff;
  logic [3:0]                 d_eff;
  logic [CNT_W:0]             last_cnt;
  logic                       mul_last;
  logic [ORD_IDX_W-1:0]       pair_idx;
  logic [HIST_IDX_W-1:0]      tap_idx;
  logic signed [SAMPLE_W-1:0] u_clamped;
  logic signed [COEF_W-1:0]   op_coef;
  logic signed [SAMPLE_W-1:0] op_sample;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_biased;
  logic signed [YFULL_W-1:0]  y_full;
  logic signed [YFULL_W-1:0]  y_clamped;
  logic signed [SAMPLE_W-1:0] y_sat;
  mac_ctrl_t                  mac_ctrl;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // Out-of-range order and delay are folded into the usable range.
  always_comb begin
    if (model_order_r == 4'd0) begin
      n_eff = 4'd1;
    end else if (model_order_r > 4'(MAX_ORDER)) begin
      n_eff = 4'(MAX_ORDER);
    end else begin
      n_eff = model_order_r;
    end
    if (delay_taps_r > 4'(MAX_DELAY)) begin
      d_eff = 4'(MAX_DELAY);
    end else begin
      d_eff = delay_taps_r;
    end
  end

  // Two products per coefficient pair: even steps B*u, odd steps A*y.
  assign last_cnt = {n_eff[CNT_W-1:0], 1'b0} - (CNT_W+1)'(1);
  assign mul_last = (cnt_r == last_cnt[CNT_W-1:0]);
  assign pair_idx = cnt_r[CNT_W-1:1];
  assign tap_idx  = HIST_IDX_W'(pair_idx) + HIST_IDX_W'(d_eff);

  assign op_coef   = cnt_r[0] ? coef_a_r[pair_idx] : coef_b_r[pair_idx];
  assign op_sample = cnt_r[0] ? yhist_r[pair_idx]  : uhist_r[tap_idx];

  always_comb begin
    mac_ctrl.clear = in_acc && (in_mode == MODE_SIM);
    mac_ctrl.issue = (state_r == S_MUL);
    mac_ctrl.neg   = cnt_r[0];
  end

  arx_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mac_ctrl),
    .op_coef   (op_coef),
    .op_sample (op_sample),
    .acc       (acc)
  );

  // Input clamp. With inverted limits a sample below the lower limit takes the lower limit; any other takes the upper.
  always_comb begin
    u_clamped = in_sample_in;
    if (clamp_enable_r[0]) begin
      if (in_sample_in < input_low_r) begin
        u_clamped = input_low_r;
      end else if (in_sample_in > input_high_r) begin
        u_clamped = input_high_r;
      end
    end
  end

  // Round to Q8.8 with halves going up, add the disturbance, clamp and
  // saturate to the sample range.
  always_comb begin
    acc_biased = acc + ACC_W'(1 << (FRAC_SHIFT - 1));
    y_full     = YFULL_W'(signed'(acc_biased[ACC_W-1:FRAC_SHIFT])) + YFULL_W'(noise_r);
    y_clamped  = y_full;
    if (clamp_enable_r[1]) begin
      if (y_full < YFULL_W'(output_low_r)) begin
        y_clamped = YFULL_W'(output_low_r);
      end else if (y_full > YFULL_W'(output_high_r)) begin
        y_clamped = YFULL_W'(output_high_r);
      end
    end
    if (y_clamped > YFULL_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}))) begin
      y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (y_clamped < YFULL_W'(signed'({1'b1, {(SAMPLE_W-1){1'b0}}}))) begin
      y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = y_clamped[SAMPLE_W-1:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == MODE_SIM)) begin
          state_nxt = S_MUL;
          cnt_nxt   = '0;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (mul_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc && (in_mode == MODE_SIM)) begin
      noise_r <= in_noise_in;
    end
    if (state_r == S_ROUND) begin
      y_r <= y_sat;
    end
    if (emit_fire) begin
      out_data_r <= y_r;
    end
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_taps_r   <= 4'd0;
      model_order_r  <= 4'd1;
      input_low_r    <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      input_high_r   <= {1'b0, {(SAMPLE_W-1){1'b1}}};
      output_low_r   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      output_high_r  <= {1'b0, {(SAMPLE_W-1){1'b1}}};
      clamp_enable_r <= 2'b11;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELAY_TAPS:   delay_taps_r   <= cfg_data[3:0];
        CFG_MODEL_ORDER:  model_order_r  <= cfg_data[3:0];
        CFG_INPUT_LOW:    input_low_r    <= signed'(cfg_data[SAMPLE_W-1:0]);
        CFG_INPUT_HIGH:   input_high_r   <= signed'(cfg_data[SAMPLE_W-1:0]);
        CFG_OUTPUT_LOW:   output_low_r   <= signed'(cfg_data[SAMPLE_W-1:0]);
        CFG_OUTPUT_HIGH:  output_high_r  <= signed'(cfg_data[SAMPLE_W-1:0]);
        CFG_CLAMP_ENABLE: clamp_enable_r <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // Coefficient stores. The index field cannot exceed the store depth here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        coef_a_r[k] <= '0;
        coef_b_r[k] <= '0;
      end
    end else if (in_acc && (in_mode == MODE_LOAD)) begin
      coef_a_r[in_coef_index[ORD_IDX_W-1:0]] <= in_coef_a;
      coef_b_r[in_coef_index[ORD_IDX_W-1:0]] <= in_coef_b;
    end
  end

  // Input history: the clamped sample enters when the transaction is taken,
  // so it is already the newest entry while the products are formed.
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && (in_mode == MODE_CLEAR))) begin
      for (int k = 0; k < IN_DEPTH; k++) begin
        uhist_r[k] <= '0;
      end
    end else if (in_acc && (in_mode == MODE_SIM)) begin
      for (int k = IN_DEPTH - 1; k > 0; k--) begin
        uhist_r[k] <= uhist_r[k-1];
      end
      uhist_r[0] <= u_clamped;
    end
  end

  // Output history: the new y enters when it is handed to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && (in_mode == MODE_CLEAR))) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        yhist_r[k] <= '0;
      end
    end else if (emit_fire) begin
      for (int k = MAX_ORDER - 1; k > 0; k--) begin
        yhist_r[k] <= yhist_r[k-1];
      end
      yhist_r[0] <= y_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

endmodule
